[rtl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, codes and constants of the segment address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int SEGMENT_SLOTS = 16;
    localparam int SLOT_W        = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;

    localparam int ADDR_W     = 32;
    localparam int INDEX_W    = 4;
    localparam int BYTES_W    = 5;
    localparam int DIV_STEPS  = ADDR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [ADDR_W-1:0] MAX_SEG_SIZE_RESET = 32'd64;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [1:0] SIZE_4      = 2'd0;
    localparam logic [1:0] SIZE_8      = 2'd1;
    localparam logic [1:0] SIZE_16     = 2'd2;
    localparam logic [1:0] SIZE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_SEG_FAULT = 2'd2
    } t_status;

    // classified request as held in the queue between front and back
    typedef struct packed {
        logic                is_write;
        logic [INDEX_W-1:0]  slot_index;
        logic                slot_valid;
        logic [ADDR_W-1:0]   entry_id;
        logic [ADDR_W-1:0]   entry_base;
        logic [ADDR_W-1:0]   entry_limit;
        logic [ADDR_W-1:0]   logical_address;
        logic [BYTES_W-1:0]  access_bytes;
        logic                check_bounds;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  physical_address;
        logic [ADDR_W-1:0]  segment_number;
        logic [ADDR_W-1:0]  segment_offset;
    } t_result;

    typedef struct packed {
        logic               start;
        logic [ADDR_W-1:0]  dividend;
        logic [ADDR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [ADDR_W-1:0]  quotient;
        logic [ADDR_W-1:0]  remainder;
    } t_div_rsp;

    function automatic logic [BYTES_W-1:0] access_bytes(input logic [1:0] code);
        logic [BYTES_W-1:0] bytes;
        unique case (code)
            SIZE_8:  bytes = 5'd8;
            SIZE_16: bytes = 5'd16;
            default: bytes = 5'd4;
        endcase
        return bytes;
    endfunction

endpackage

[rtl/sat_front.sv]
// ----------------------------------------------------------------------------
// sat_front
// Accepts requests, decodes them into command records and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module sat_front
    import sat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_cmd,
    input  logic [INDEX_W-1:0]  i_slot_index,
    input  logic                i_slot_valid,
    input  logic [ADDR_W-1:0]   i_entry_id,
    input  logic [ADDR_W-1:0]   i_entry_base,
    input  logic [ADDR_W-1:0]   i_entry_limit,
    input  logic [ADDR_W-1:0]   i_logical_address,
    input  logic [1:0]          i_size_code,
    input  logic                i_check_bounds,
    output logic                o_head_valid,
    output t_cmd                o_head,
    input  logic                i_head_pop
);

    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                push_ok;
    logic                pop_ok;
    t_cmd                cmd;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_head_pop && o_head_valid;

    always_comb begin
        cmd.is_write        = (i_cmd == CMD_WRITE);
        cmd.slot_index      = i_slot_index;
        cmd.slot_valid      = i_slot_valid;
        cmd.entry_id        = i_entry_id;
        cmd.entry_base      = i_entry_base;
        cmd.entry_limit     = i_entry_limit;
        cmd.logical_address = i_logical_address;
        cmd.access_bytes    = access_bytes(i_size_code);
        cmd.check_bounds    = i_check_bounds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

[rtl/sat_divider.sv]
// ----------------------------------------------------------------------------
// sat_divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle. The divisor
// must be non-zero.
// ----------------------------------------------------------------------------
module sat_divider
    import sat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic [ADDR_W-1:0]     r_rem;
    logic [ADDR_W-1:0]     r_quo;
    logic [ADDR_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [ADDR_W:0]       shifted;
    logic [ADDR_W:0]       diff;

    assign shifted = {r_rem, r_quo[ADDR_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            // trial subtract, keep the shifted remainder when it goes negative
            if (!diff[ADDR_W]) begin
                r_rem <= diff[ADDR_W-1:0];
            end else begin
                r_rem <= shifted[ADDR_W-1:0];
            end
            r_quo <= {r_quo[ADDR_W-2:0], ~diff[ADDR_W]};
        end
    end

endmodule

[rtl/sat_back.sv]
// ----------------------------------------------------------------------------
// sat_back
// Executes queued commands: segment table writes, address split through the
// divider, id search, bounds check and the result register.
// ----------------------------------------------------------------------------
module sat_back
    import sat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ADDR_W-1:0]  i_max_seg_size,
    input  logic               i_head_valid,
    input  t_cmd               i_head,
    output logic               o_head_pop,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    input  logic               i_out_pop,
    output logic               o_out_valid,
    output t_result            o_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_LOOK = 6'b000100,
        S_SEL  = 6'b001000,
        S_CALC = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [SEGMENT_SLOTS-1:0]  r_slot_valid;
    logic [ADDR_W-1:0]         r_slot_id    [SEGMENT_SLOTS];
    logic [ADDR_W-1:0]         r_slot_base  [SEGMENT_SLOTS];
    logic [ADDR_W-1:0]         r_slot_limit [SEGMENT_SLOTS];

    t_cmd                      r_item;
    logic [ADDR_W-1:0]         r_segnum;
    logic [ADDR_W-1:0]         r_offset;
    logic [SEGMENT_SLOTS-1:0]  r_match;
    logic                      r_hit;
    logic [ADDR_W-1:0]         r_base;
    logic [ADDR_W-1:0]         r_limit;
    logic [ADDR_W-1:0]         r_span;
    logic [ADDR_W:0]           r_end;
    logic [ADDR_W-1:0]         r_phys;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      head_pop;
    logic                      size_zero;
    logic                      slot_in_range;
    logic [SLOT_W-1:0]         wr_slot;
    logic [SLOT_W-1:0]         hit_idx;
    logic                      out_load;
    t_result                   result;

    assign head_pop      = (r_state == S_IDLE) && i_head_valid;
    assign size_zero     = (i_max_seg_size == '0);
    assign slot_in_range = (32'(i_head.slot_index) < 32'(SEGMENT_SLOTS));
    assign wr_slot       = SLOT_W'(i_head.slot_index);
    assign out_load      = (r_state == S_EMIT) && (!r_out_valid || i_out_pop);

    assign o_head_pop         = head_pop;
    assign o_div_req.start    = head_pop && !i_head.is_write && !size_zero;
    assign o_div_req.dividend = i_head.logical_address;
    assign o_div_req.divisor  = i_max_seg_size;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // lowest-numbered matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = SEGMENT_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        result.status           = ST_OK;
        result.physical_address = '0;
        result.segment_number   = '0;
        result.segment_offset   = '0;
        if (!r_item.is_write) begin
            result.segment_number = r_segnum;
            result.segment_offset = r_offset;
            if (!r_hit) begin
                result.status = ST_NOT_FOUND;
            end else if (r_item.check_bounds && (r_end > {1'b0, r_span})) begin
                result.status = ST_SEG_FAULT;
            end else begin
                result.physical_address = r_phys;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.is_write) begin
                        n_state = S_EMIT;
                    end else if (size_zero) begin
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_SEL;
            S_SEL:  n_state = S_CALC;
            S_CALC: n_state = S_EMIT;
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (head_pop && i_head.is_write && slot_in_range) begin
                r_slot_valid[wr_slot] <= i_head.slot_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_pop) begin
            r_item <= i_head;
            if (i_head.is_write && slot_in_range) begin
                r_slot_id[wr_slot]    <= i_head.entry_id;
                r_slot_base[wr_slot]  <= i_head.entry_base;
                r_slot_limit[wr_slot] <= i_head.entry_limit;
            end
            // zero segment size: all-ones number, whole address as offset
            r_segnum <= '1;
            r_offset <= i_head.logical_address;
        end
        if ((r_state == S_DIV) && i_div_rsp.done) begin
            r_segnum <= i_div_rsp.quotient;
            r_offset <= i_div_rsp.remainder;
        end
        if (r_state == S_LOOK) begin
            for (int i = 0; i < SEGMENT_SLOTS; i++) begin
                r_match[i] <= r_slot_valid[i] && (r_slot_id[i] == r_segnum);
            end
        end
        if (r_state == S_SEL) begin
            r_hit   <= |r_match;
            r_base  <= r_slot_base[hit_idx];
            r_limit <= r_slot_limit[hit_idx];
        end
        if (r_state == S_CALC) begin
            r_span <= r_limit - r_base;
            r_end  <= {1'b0, r_offset} + (ADDR_W + 1)'(r_item.access_bytes);
            r_phys <= r_base + r_offset;
        end
        if (out_load) begin
            r_out <= result;
        end
    end

endmodule

[rtl/segment_address_translator.sv]
// ----------------------------------------------------------------------------
// segment_address_translator
// Base/limit segmentation: a segment table of 16 slots, written by request,
// and translation of logical addresses into physical ones.
// ----------------------------------------------------------------------------
// Requests enter through a queue port: push is taken when full is low. Each
// request gives exactly one result, in request order, shown on the result
// ports while empty is low and taken by pop. The segment size register is
// written over its own valid/ready channel (ready is always high); the user
// must write it only while the block is idle; the block does not check it.
// A two-entry request queue sits in front of a sequencer, and a result
// register behind it, so requests keep being taken while a result waits.
// A table write goes from the queue head straight to the result register;
// a translate request passes the 32-step divider that splits the address
// into segment number and offset, then the id search, the bounds arithmetic
// and the result register; with a zero segment size the divider is skipped.
// One request is worked on at a time, so the next one is taken from the queue
// only once the last result has been loaded into the result register.
// After reset all slots are invalid and the segment size is 64. If pop stays
// low the result register holds, then the sequencer stops, then the queue
// fills and full goes high.
// ----------------------------------------------------------------------------
module segment_address_translator
    import sat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_cmd,
    input  logic [INDEX_W-1:0]  i_slot_index,
    input  logic                i_slot_valid,
    input  logic [ADDR_W-1:0]   i_entry_id,
    input  logic [ADDR_W-1:0]   i_entry_base,
    input  logic [ADDR_W-1:0]   i_entry_limit,
    input  logic [ADDR_W-1:0]   i_logical_address,
    input  logic [1:0]          i_size_code,
    input  logic                i_check_bounds,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_status,
    output logic [ADDR_W-1:0]   o_physical_address,
    output logic [ADDR_W-1:0]   o_segment_number,
    output logic [ADDR_W-1:0]   o_segment_offset,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ADDR_W-1:0]   i_cfg_data
);

    logic [ADDR_W-1:0]  r_max_seg_size;
    logic               head_valid;
    t_cmd               head;
    logic               head_pop;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               out_valid;
    t_result            out_res;
    logic               out_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seg_size <= MAX_SEG_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_seg_size <= i_cfg_data;
        end
    end

    sat_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_cmd             (i_cmd),
        .i_slot_index      (i_slot_index),
        .i_slot_valid      (i_slot_valid),
        .i_entry_id        (i_entry_id),
        .i_entry_base      (i_entry_base),
        .i_entry_limit     (i_entry_limit),
        .i_logical_address (i_logical_address),
        .i_size_code       (i_size_code),
        .i_check_bounds    (i_check_bounds),
        .o_head_valid      (head_valid),
        .o_head            (head),
        .i_head_pop        (head_pop)
    );

    sat_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sat_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_seg_size (r_max_seg_size),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_head_pop     (head_pop),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .i_out_pop      (out_pop),
        .o_out_valid    (out_valid),
        .o_out          (out_res)
    );

    assign empty   = !out_valid;
    assign out_pop = pop && out_valid;

    assign o_status           = out_res.status;
    assign o_physical_address = out_res.physical_address;
    assign o_segment_number   = out_res.segment_number;
    assign o_segment_offset   = out_res.segment_offset;

endmodule
